@@ design/oets_pkg.sv @@
// shared types and constants for the odd-even transposition sorter
// used by oets_cell and odd_even_transposition_sorter_top; no dependencies
package oets_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // cell operation codes
  localparam logic [1:0] MODE_HOLD  = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_PHASE = 2'd2;
  localparam logic [1:0] MODE_SHIFT = 2'd3;

  // input word
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_set;
    logic               overflowed;
  } out_word_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic [1:0]       mode;
    logic             parity;
    logic [CNT_W-1:0] pos;
  } cell_ctrl_t;

endpackage

@@ design/oets_cell.sv @@
// one element slot of the sorter chain: load, compare-exchange, shift
// depends on oets_pkg
module oets_cell (
  input  logic                      clk,
  input  logic [oets_pkg::CNT_W-1:0] idx,
  input  oets_pkg::cell_ctrl_t      ctrl,
  input  logic signed [31:0]        load_val,
  input  logic signed [31:0]        left_val,
  input  logic signed [31:0]        right_val,
  input  logic                      swap_in,
  output logic                      swap_out,
  output logic signed [31:0]        value
);

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;
  logic               is_left;
  logic               pair_ok;

  // this cell is the lower member of an active pair in the current phase
  assign is_left  = (idx[0] == ctrl.parity);
  assign pair_ok  = ((idx + oets_pkg::CNT_W'(1)) < ctrl.pos);
  assign swap_out = (ctrl.mode == oets_pkg::MODE_PHASE) && is_left && pair_ok &&
                    (value_r > right_val);

  // next value of the slot
  always_comb begin
    value_nxt = value_r;
    case (ctrl.mode)
      oets_pkg::MODE_LOAD: begin
        if (ctrl.pos == idx) value_nxt = load_val;
      end
      oets_pkg::MODE_PHASE: begin
        if (swap_out) value_nxt = right_val;
        else if (swap_in) value_nxt = left_val;
      end
      oets_pkg::MODE_SHIFT: value_nxt = right_val;
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

@@ design/odd_even_transposition_sorter_top.sv @@
// odd-even transposition sorter: sequencer and a chain of oets_cell slots
// depends on oets_pkg and oets_cell
//
// usage: words enter on in_word when start is high and busy is low. each
// word is stored in the next free slot; once MAX_ITEMS slots are full further
// words are dropped and the set is marked overflowed. the word with last set
// closes the set, and busy rises while the chain sorts it.
// sorting runs one compare-exchange phase per cycle over the cell chain,
// even and odd pairs alternating, and stops after two phases in a row with
// no exchange or after n phases (n = stored elements).
// the sorted set then leaves as n result words back to back, each
// marked by out_strobe, smallest first, with end_of_set on the last one.
// the receiver cannot hold results off. busy falls after the last result.
// reset (rst_n low, synchronous) returns the block to the empty loading state.
module odd_even_transposition_sorter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  oets_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output oets_pkg::out_word_t out_word
);

  localparam int N = oets_pkg::MAX_ITEMS;
  localparam int W = oets_pkg::CNT_W;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [W-1:0] count_r, count_nxt;
  logic         drop_r, drop_nxt;
  logic         parity_r, parity_nxt;
  logic [1:0]   quiet_r, quiet_nxt;
  logic [W-1:0] phase_r, phase_nxt;
  logic [W-1:0] k_r, k_nxt;

  oets_pkg::cell_ctrl_t ctrl;
  logic signed [31:0]   cell_val [N];
  logic [N-1:0]         swap;
  logic                 moved;
  logic                 accept;
  logic                 room;

  assign accept = start && (state_r == ST_LOAD);
  assign room   = (count_r < W'(N));
  assign moved  = |swap;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    drop_nxt    = drop_r;
    parity_nxt  = parity_r;
    quiet_nxt   = quiet_r;
    phase_nxt   = phase_r;
    k_nxt       = k_r;
    ctrl.mode   = oets_pkg::MODE_HOLD;
    ctrl.parity = parity_r;
    ctrl.pos    = count_r;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            ctrl.mode = oets_pkg::MODE_LOAD;
            count_nxt = count_r + W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_word.last) begin
            state_nxt  = ST_SORT;
            parity_nxt = 1'b0;
            quiet_nxt  = 2'd0;
            phase_nxt  = '0;
          end
        end
      end
      ST_SORT: begin
        if ((phase_r < count_r) && (quiet_r < 2'd2)) begin
          ctrl.mode  = oets_pkg::MODE_PHASE;
          quiet_nxt  = moved ? 2'd0 : quiet_r + 2'd1;
          parity_nxt = ~parity_r;
          phase_nxt  = phase_r + W'(1);
        end else begin
          state_nxt = ST_EMIT;
          k_nxt     = '0;
        end
      end
      ST_EMIT: begin
        ctrl.mode = oets_pkg::MODE_SHIFT;
        k_nxt     = k_r + W'(1);
        if (k_r == count_r - W'(1)) begin
          state_nxt  = ST_LOAD;
          count_nxt  = '0;
          drop_nxt   = 1'b0;
          parity_nxt = 1'b0;
          quiet_nxt  = 2'd0;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      count_r  <= '0;
      drop_r   <= 1'b0;
      parity_r <= 1'b0;
      quiet_r  <= 2'd0;
      phase_r  <= '0;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      drop_r   <= drop_nxt;
      parity_r <= parity_nxt;
      quiet_r  <= quiet_nxt;
      phase_r  <= phase_nxt;
      k_r      <= k_nxt;
    end
  end

  // chain of element cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [31:0] lv;
    logic signed [31:0] rv;
    logic               sin;
    if (i == 0) begin : g_first
      assign lv  = '0;
      assign sin = 1'b0;
    end else begin : g_mid
      assign lv  = cell_val[i-1];
      assign sin = swap[i-1];
    end
    if (i == N - 1) begin : g_last
      assign rv = '0;
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end
    oets_cell u_cell (
      .clk       (clk),
      .idx       (W'(i)),
      .ctrl      (ctrl),
      .load_val  (in_word.value),
      .left_val  (lv),
      .right_val (rv),
      .swap_in   (sin),
      .swap_out  (swap[i]),
      .value     (cell_val[i])
    );
  end

  // outputs
  assign busy                  = (state_r != ST_LOAD);
  assign out_strobe            = (state_r == ST_EMIT);
  assign out_word.sorted_value = cell_val[0];
  assign out_word.end_of_set   = (k_r == count_r - W'(1));
  assign out_word.overflowed   = drop_r;

endmodule

@@ test/sorter_checker.sv @@
// scoreboard for the odd-even transposition sorter: watches the input and result
// words, predicts each sorted burst and compares it field by field
// depends on oets_pkg
module sorter_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  oets_pkg::in_word_t  in_word,
  input  logic                out_strobe,
  input  oets_pkg::out_word_t out_word,
  output int                  errors,
  output int                  pending,
  output int                  words_taken,
  output int                  sets_closed,
  output int                  overflow_sets,
  output int                  results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted block state
  logic signed [31:0] held_values [oets_pkg::MAX_ITEMS];
  int                 held_count;
  logic               dropped;

  // sorted words still due from the block, oldest first
  oets_pkg::out_word_t expected_words [$];

  // odd-even transposition over the held elements, even phase first,
  // stopping after two quiet phases in a row or after n phases
  task automatic transpose_sort(input int n);
    int                 phases;
    int                 quiet;
    int                 parity;
    bit                 moved;
    logic signed [31:0] swap_tmp;
    phases = 0;
    quiet  = 0;
    parity = 0;
    while (phases < n && quiet < 2) begin
      moved = 1'b0;
      for (int i = parity; i + 1 < n; i += 2) begin
        if (held_values[i] > held_values[i+1]) begin
          swap_tmp         = held_values[i];
          held_values[i]   = held_values[i+1];
          held_values[i+1] = swap_tmp;
          moved            = 1'b1;
        end
      end
      quiet  = moved ? 0 : quiet + 1;
      parity = 1 - parity;
      phases++;
    end
  endtask

  // close the set: sort it and queue one expected word per stored element
  task automatic close_set();
    int                  n;
    oets_pkg::out_word_t w;
    n = held_count;
    transpose_sort(n);
    for (int k = 0; k < n; k++) begin
      w.sorted_value = held_values[k];
      w.end_of_set   = (k == n - 1);
      w.overflowed   = dropped;
      expected_words.push_back(w);
    end
    sets_closed++;
    if (dropped) overflow_sets++;
    held_count = 0;
    dropped    = 1'b0;
  endtask

  always @(posedge clk) begin
    oets_pkg::out_word_t want;
    if (!rst_n) begin
      held_count      = 0;
      dropped         = 1'b0;
      expected_words.delete();
      errors          = 0;
      words_taken     = 0;
      sets_closed     = 0;
      overflow_sets   = 0;
      results_checked = 0;
    end else begin
      // result words first: none of them can belong to a set closing now
      if (out_strobe) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: value %0d end %0b ovf %0b", $time,
                   out_word.sorted_value, out_word.end_of_set, out_word.overflowed);
        end else begin
          want = expected_words.pop_front();
          results_checked++;
          if (out_word.sorted_value !== want.sorted_value ||
              out_word.end_of_set !== want.end_of_set ||
              out_word.overflowed !== want.overflowed) begin
            errors++;
            $display("%0t: result mismatch: expected value %0d end %0b ovf %0b,",
                     $time, want.sorted_value, want.end_of_set, want.overflowed);
            $display("%0t:   got value %0d end %0b ovf %0b", $time,
                     out_word.sorted_value, out_word.end_of_set, out_word.overflowed);
          end
        end
      end
      // accepted input word: store it or drop it once the store is full
      if (start && !busy) begin
        words_taken++;
        if (held_count < oets_pkg::MAX_ITEMS) begin
          held_values[held_count] = in_word.value;
          held_count++;
        end else begin
          dropped = 1'b1;
        end
        if (in_word.last) close_set();
      end
    end
    pending = expected_words.size();
  end

endmodule

@@ test/testbench.sv @@
// top of the sorter regression: clock, reset, input words and the verdict
// depends on oets_pkg, odd_even_transposition_sorter_top and sorter_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS   = 90;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 2 * oets_pkg::MAX_ITEMS + 8;
  localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  oets_pkg::in_word_t  in_word = '0;
  logic                out_strobe;
  oets_pkg::out_word_t out_word;

  int errors;
  int pending;
  int words_taken;
  int sets_closed;
  int overflow_sets;
  int results_checked;

  int idle_cycles = 0;
  bit steady      = 1'b1;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  odd_even_transposition_sorter_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  sorter_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_word         (in_word),
    .out_strobe      (out_strobe),
    .out_word        (out_word),
    .errors          (errors),
    .pending         (pending),
    .words_taken     (words_taken),
    .sets_closed     (sets_closed),
    .overflow_sets   (overflow_sets),
    .results_checked (results_checked)
  );

  // watchdog: cycles with neither an input word nor a result word taken
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no traffic for %0d cycles", $time, idle_cycles);
      $display("odd_even_transposition_sorter_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one word, with an occasional gap before it, and wait until taken
  task automatic send_word(input logic signed [31:0] elem, input logic closes);
    int gap;
    if (!steady && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_word.value <= elem;
    in_word.last  <= closes;
    do @(posedge clk); while (busy);
  endtask

  // element mix: extremes, a narrow band for duplicates, full-range noise
  function automatic logic signed [31:0] pick_element();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2, 3, 4: return $signed(32'($urandom_range(0, 7))) - 32'sd4;
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    int first_random;
    int set_size;
    int set_index;
    int sel;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-element set
    send_word(MOST_NEGATIVE, 1'b1);
    // two extremes in reverse order
    send_word(MOST_POSITIVE, 1'b0);
    send_word(MOST_NEGATIVE, 1'b1);
    // duplicate elements near zero, mixed with an extreme
    send_word(32'sd0, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(MOST_POSITIVE, 1'b0);
    send_word(-32'sd1, 1'b1);
    // full store, mixed signs, then one dropped word and a dropped closing word
    for (int k = 0; k < oets_pkg::MAX_ITEMS; k++) begin
      send_word((k % 2 == 0) ? 32'(oets_pkg::MAX_ITEMS - k) : -32'(k), 1'b0);
    end
    send_word(pick_element(), 1'b0);
    send_word(pick_element(), 1'b1);

    // random sets, mostly small, some full, a few past capacity
    first_random = words_taken;
    set_index    = 0;
    while (words_taken - first_random < RANDOM_WORDS) begin
      steady = (set_index >= 10 && set_index < 16);
      sel    = $urandom_range(0, 99);
      if (sel < 70)      set_size = $urandom_range(1, 6);
      else if (sel < 90) set_size = $urandom_range(7, oets_pkg::MAX_ITEMS);
      else               set_size = $urandom_range(oets_pkg::MAX_ITEMS + 1,
                                                   oets_pkg::MAX_ITEMS + 4);
      for (int k = 0; k < set_size; k++) begin
        send_word(pick_element(), k == set_size - 1);
      end
      set_index++;
    end
    start <= 1'b0;

    // drain the last burst, then give stray words time to show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d input words in %0d sets, %0d of them over capacity",
             words_taken, sets_closed, overflow_sets);
    $display("checked %0d sorted result words", results_checked);
    if (errors == 0 && pending == 0) begin
      $display("odd_even_transposition_sorter_top regression: pass");
    end else begin
      if (pending != 0) $display("%0d expected result words never arrived", pending);
      $display("odd_even_transposition_sorter_top regression: fail");
    end
    $finish;
  end

endmodule
